@@ hdl/rau_pkg.sv @@
// Package for the rational arithmetic unit: widths, action codes, sequencer states and divider control.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
  localparam int OperandWidth = 32;
  localparam int WideWidth    = 64;
  localparam int CountWidth   = 7;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_RED = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_COMB,
    ST_CHECK,
    ST_GSHIFT,
    ST_GODD,
    ST_GLOOP,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage
`default_nettype wire

@@ hdl/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: sequencer, shared multiplier and gcd datapath.
// Depends on rau_pkg and rau_divider.
//
// Usage: an input beat (action, a_num, a_den, b_num, b_den) is taken when in_valid and
// in_ready are high; in_ready is low while an item is being worked on. The result beat
// (result_num, result_den, zero_den_error) is offered on out_valid until out_ready.
// Arithmetic without reduction forms three products one after another on one shared
// 32x32 multiplier. Reduction adds the binary gcd, one shift or subtract per cycle, and
// two restoring divisions on the shared divider. One item is in flight at a time.
// The next item is accepted while a finished result waits on a stalled receiver, and it
// runs up to its own result, which then waits for the output register to empty.
// Reset clears the sequencer, the output valid and reduce_after; cfg_we writes
// reduce_after from cfg_data[0].
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [31:0] a_num,
  input  wire logic [31:0] a_den,
  input  wire logic [31:0] b_num,
  input  wire logic [31:0] b_den,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      result_num,
  output logic [63:0]      result_den,
  output logic             zero_den_error
);
  import rau_pkg::*;

  state_t state, state_next;
  logic reduce_after;
  logic [2:0] act;
  logic signed [WideWidth-1:0] an, ad, bn, bd;
  logic [WideWidth-1:0] rn, rd, p0, p1, gx, gy, gmag;
  logic [CountWidth-1:0] shift;
  logic [OperandWidth-1:0] mul_a, mul_b;
  logic [WideWidth-1:0] mul_p;
  logic [WideWidth-1:0] div_in, div_q;
  logic div_start;
  logic div_started;
  div_ctl_t dctl;

  function automatic logic [WideWidth-1:0] sext(input logic [31:0] v);
    return WideWidth'($signed(v[OperandWidth-1:0]));
  endfunction
  function automatic logic [WideWidth-1:0] mag(input logic [WideWidth-1:0] v);
    return v[WideWidth-1] ? (~v + 1'b1) : v;
  endfunction

  // Low 64 bits of a 64x64 product of sign-extended 32-bit operands equal the
  // signed 32x32 product.
  assign mul_p = WideWidth'($signed(mul_a) * $signed(mul_b));

  always_comb begin
    mul_a = an[OperandWidth-1:0]; mul_b = bd[OperandWidth-1:0];
    unique case (state)
      ST_MUL1: begin
        mul_a = an[OperandWidth-1:0];
        mul_b = (act == ACT_MUL) ? bn[OperandWidth-1:0] : bd[OperandWidth-1:0];
      end
      ST_MUL2: begin mul_a = bn[OperandWidth-1:0]; mul_b = ad[OperandWidth-1:0]; end
      ST_MUL3: begin
        mul_a = ad[OperandWidth-1:0];
        mul_b = (act == ACT_DIV) ? bn[OperandWidth-1:0] : bd[OperandWidth-1:0];
      end
      default: ;
    endcase
  end

  assign div_in = (state == ST_DIVN) ? mag(rn) : mag(rd);

  rau_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_in),
    .divisor(gmag), .ctl(dctl), .quotient(div_q)
  );

  logic arith;
  assign arith = (act == ACT_ADD) || (act == ACT_SUB) || (act == ACT_MUL) ||
                 (act == ACT_DIV);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MUL1;
      ST_MUL1:  state_next = arith ? ST_MUL2 : ST_CHECK;
      ST_MUL2:  state_next = ST_MUL3;
      ST_MUL3:  state_next = ST_COMB;
      ST_COMB:  state_next = ST_CHECK;
      ST_CHECK: begin
        if ((act == ACT_RED) || (arith && reduce_after))
          state_next = (rd == '0 || rn == '0) ? ST_DONE : ST_GSHIFT;
        else
          state_next = ST_DONE;
      end
      ST_GSHIFT: if ((gx[0] | gy[0]) == 1'b1) state_next = ST_GODD;
      ST_GODD:   if (gx[0]) state_next = ST_GLOOP;
      ST_GLOOP:  if (gy == '0) state_next = ST_DIVN;
      ST_DIVN:   if (!dctl.start && !dctl.busy && div_started) state_next = ST_DIVD;
      ST_DIVD:   if (!dctl.start && !dctl.busy && div_started) state_next = ST_DONE;
      ST_DONE:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    div_start = ((state == ST_DIVN) || (state == ST_DIVD)) && !div_started;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      reduce_after <= 1'b0;
      out_valid    <= 1'b0;
      div_started  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) reduce_after <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      if (div_start) div_started <= 1'b1;
      else if (div_started && !dctl.busy && !dctl.start) div_started <= 1'b0;
    end
  end

  logic err;
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (in_valid) begin
        act <= action;
        an <= sext(a_num); ad <= sext(a_den); bn <= sext(b_num); bd <= sext(b_den);
        err <= 1'b0;
      end
      ST_MUL1: begin
        p0 <= mul_p; rn <= an; rd <= ad;
      end
      ST_MUL2: p1 <= mul_p;
      ST_MUL3: rd <= mul_p;
      ST_COMB: begin
        if ((act == ACT_ADD || act == ACT_SUB) && ad == bd) begin
          rn <= (act == ACT_ADD) ? an + bn : an - bn;
          rd <= ad;
        end else if (act == ACT_ADD) rn <= p0 + p1;
        else if (act == ACT_SUB) rn <= p0 - p1;
        else rn <= p0;
      end
      ST_CHECK: begin
        gx <= mag(rn); gy <= mag(rd); shift <= '0;
        if ((act == ACT_RED) || (arith && reduce_after)) begin
          if (rd == '0) err <= 1'b1;
          else if (rn == '0) rd <= WideWidth'(1);
        end
      end
      ST_GSHIFT: if ((gx[0] | gy[0]) == 1'b0) begin
        gx <= gx >> 1; gy <= gy >> 1; shift <= shift + 1'b1;
      end
      ST_GODD: if (!gx[0]) gx <= gx >> 1;
      ST_GLOOP: begin
        if (gy == '0) gmag <= gx << shift[5:0];
        else if (!gy[0]) gy <= gy >> 1;
        else if (gx > gy) begin gy <= gx - gy; gx <= gy; end
        else gy <= gy - gx;
      end
      ST_DIVN: if (div_started && !dctl.busy && !dctl.start)
        rn <= rn[WideWidth-1] ? (~div_q + 1'b1) : div_q;
      ST_DIVD: if (div_started && !dctl.busy && !dctl.start)
        rd <= rd[WideWidth-1] ? (~div_q + 1'b1) : div_q;
      ST_DONE: if (!out_valid || out_ready) begin
        result_num <= rn; result_den <= rd; zero_den_error <= err;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/rau_divider.sv @@
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rau_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [rau_pkg::WideWidth-1:0] dividend,
  input  wire logic [rau_pkg::WideWidth-1:0] divisor,
  output rau_pkg::div_ctl_t                 ctl,
  output logic [rau_pkg::WideWidth-1:0]     quotient
);
  import rau_pkg::*;

  logic [WideWidth-1:0]  rem;
  logic [WideWidth-1:0]  dvs;
  logic [CountWidth-1:0] count;
  logic                  busy;
  logic [WideWidth:0]    trial;

  assign trial = {rem, quotient[WideWidth-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      count    <= CountWidth'(WideWidth);
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      // The quotient register doubles as the dividend shift register.
      if (!trial[WideWidth]) begin
        rem      <= trial[WideWidth-1:0];
        quotient <= {quotient[WideWidth-2:0], 1'b1};
      end else begin
        rem      <= {rem[WideWidth-2:0], quotient[WideWidth-1]};
        quotient <= {quotient[WideWidth-2:0], 1'b0};
      end
      count <= count - 1'b1;
      if (count == CountWidth'(1)) busy <= 1'b0;
    end
  end

  assign ctl = {start, busy};
endmodule
`default_nettype wire
